/* hw/rtl/fcpa_pkg.sv */
package fcpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int CHUNK_W    = 17;
    localparam int COUNT_W    = 9;
    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int PROD_W     = IDX_W + CHUNK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_OFF     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALL_FREE = 2'd3;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic set_full;
        logic pop;
        logic mul;
        logic add;
        logic check;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic empty;
        logic div_busy;
    } t_stat;

endpackage

/* hw/rtl/fcpa_in_if.sv */
interface fcpa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [fcpa_pkg::ADDR_W-1:0] release_address;
    logic                        skip_check;

    modport source (output valid, output action, output release_address,
                    output skip_check, input ready);
    modport sink   (input valid, input action, input release_address,
                    input skip_check, output ready);
endinterface

/* hw/rtl/fcpa_out_if.sv */
interface fcpa_out_if;
    logic                          valid;
    logic                          ready;
    logic [fcpa_pkg::STATUS_W-1:0] status;
    logic [fcpa_pkg::ADDR_W-1:0]   chunk_address;
    logic [fcpa_pkg::COUNT_W-1:0]  free_chunks;

    modport source (output valid, output status, output chunk_address,
                    output free_chunks, input ready);
    modport sink   (input valid, input status, input chunk_address,
                    input free_chunks, output ready);
endinterface

/* hw/rtl/fcpa_div.sv */
module fcpa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fcpa_pkg::ADDR_W-1:0]  i_dividend,
    input  logic [fcpa_pkg::CHUNK_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic [fcpa_pkg::ADDR_W-1:0]  o_quotient,
    output logic [fcpa_pkg::CHUNK_W-1:0] o_remainder
);

    localparam int STEP_W = $clog2(fcpa_pkg::ADDR_W);

    logic                         r_busy;
    logic [STEP_W-1:0]            r_step;
    logic [fcpa_pkg::ADDR_W-1:0]  r_quo;
    logic [fcpa_pkg::CHUNK_W-1:0] r_rem;
    logic [fcpa_pkg::CHUNK_W-1:0] r_div;

    logic [fcpa_pkg::CHUNK_W:0]   trial;
    logic [fcpa_pkg::CHUNK_W+1:0] diff;
    logic                         fits;
    logic [fcpa_pkg::CHUNK_W-1:0] n_rem;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_quo[fcpa_pkg::ADDR_W-1]};
        diff  = {1'b0, trial} - {2'b00, r_div};
        fits  = !diff[fcpa_pkg::CHUNK_W+1];
        n_rem = fits ? diff[fcpa_pkg::CHUNK_W-1:0] : trial[fcpa_pkg::CHUNK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(fcpa_pkg::ADDR_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fcpa_pkg::ADDR_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hw/rtl/fcpa_dp.sv */
module fcpa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fcpa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_action,
    input  logic [fcpa_pkg::ADDR_W-1:0]    i_release_address,
    input  logic                           i_skip_check,
    input  fcpa_pkg::t_cmd                 i_cmd,
    output fcpa_pkg::t_stat                o_stat,
    output logic [fcpa_pkg::STATUS_W-1:0]  o_status,
    output logic [fcpa_pkg::ADDR_W-1:0]    o_chunk_address,
    output logic [fcpa_pkg::COUNT_W-1:0]   o_free_chunks
);

    // configuration
    logic [fcpa_pkg::ADDR_W-1:0]   r_base;
    logic [fcpa_pkg::CHUNK_W-1:0]  r_chunk;
    logic [fcpa_pkg::COUNT_W-1:0]  r_cnt_cfg;
    logic                          r_check_off;

    // free stack
    logic [fcpa_pkg::COUNT_W-1:0]  r_count;
    logic [fcpa_pkg::MAX_CHUNKS-1:0] r_vld;
    logic [fcpa_pkg::IDX_W-1:0]    r_mem [fcpa_pkg::MAX_CHUNKS];
    logic [fcpa_pkg::IDX_W-1:0]    r_rd_data;
    logic                          r_rd_vld;
    logic [fcpa_pkg::IDX_W-1:0]    r_rd_idx;

    // current item and its result
    logic                          r_action;
    logic [fcpa_pkg::ADDR_W-1:0]   r_addr;
    logic                          r_skip;
    logic [fcpa_pkg::PROD_W-1:0]   r_prod;
    logic [fcpa_pkg::STATUS_W-1:0] r_status;
    logic [fcpa_pkg::ADDR_W-1:0]   r_res_addr;
    logic [fcpa_pkg::STATUS_W-1:0] r_o_status;
    logic [fcpa_pkg::ADDR_W-1:0]   r_o_addr;
    logic [fcpa_pkg::COUNT_W-1:0]  r_o_free;

    logic [fcpa_pkg::CHUNK_W-1:0]  eff_chunk;
    logic [fcpa_pkg::COUNT_W-1:0]  eff_count;
    logic [fcpa_pkg::COUNT_W-1:0]  n_cfg_count;
    logic [fcpa_pkg::COUNT_W-1:0]  count_dec;
    logic [fcpa_pkg::IDX_W-1:0]    pop_idx;
    logic [fcpa_pkg::IDX_W-1:0]    push_idx;
    logic [fcpa_pkg::IDX_W-1:0]    idx_eff;
    logic [fcpa_pkg::ADDR_W-1:0]   offset;
    logic                          div_busy;
    logic [fcpa_pkg::ADDR_W-1:0]   quo;
    logic [fcpa_pkg::CHUNK_W-1:0]  rem;
    logic                          chk_en;
    logic                          q_big;
    logic                          bad;
    logic                          all_free;
    logic                          push;
    logic                          cnt_write;

    always_comb begin
        eff_chunk   = (r_chunk == '0) ? fcpa_pkg::CHUNK_W'(1) : r_chunk;
        eff_count   = (r_cnt_cfg > fcpa_pkg::COUNT_W'(fcpa_pkg::MAX_CHUNKS))
                      ? fcpa_pkg::COUNT_W'(fcpa_pkg::MAX_CHUNKS) : r_cnt_cfg;
        n_cfg_count = (i_cfg_data[fcpa_pkg::COUNT_W-1:0]
                       > fcpa_pkg::COUNT_W'(fcpa_pkg::MAX_CHUNKS))
                      ? fcpa_pkg::COUNT_W'(fcpa_pkg::MAX_CHUNKS)
                      : i_cfg_data[fcpa_pkg::COUNT_W-1:0];
        cnt_write   = i_cfg_we && (i_cfg_idx == fcpa_pkg::CFG_CHUNKS_IN_USE);
        count_dec   = r_count - fcpa_pkg::COUNT_W'(1);
        pop_idx     = count_dec[fcpa_pkg::IDX_W-1:0];
        push_idx    = r_count[fcpa_pkg::IDX_W-1:0];
        // an entry never pushed since the last refill still holds its own index
        idx_eff     = r_rd_vld ? r_rd_data : r_rd_idx;
        offset      = r_addr - r_base;
        chk_en      = !r_skip && !r_check_off;
        q_big       = (|quo[fcpa_pkg::ADDR_W-1:fcpa_pkg::COUNT_W])
                      || (quo[fcpa_pkg::COUNT_W-1:0] >= eff_count);
        bad         = chk_en && ((r_addr < r_base) || q_big || (rem != '0));
        all_free    = r_count >= eff_count;
        push        = i_cmd.check && !bad && !all_free;
    end

    fcpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (offset),
        .i_divisor   (eff_chunk),
        .o_busy      (div_busy),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_chunk     <= fcpa_pkg::CHUNK_W'(64);
            r_cnt_cfg   <= fcpa_pkg::COUNT_W'(fcpa_pkg::MAX_CHUNKS);
            r_check_off <= 1'b0;
            r_count     <= fcpa_pkg::COUNT_W'(fcpa_pkg::MAX_CHUNKS);
            r_vld       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fcpa_pkg::CFG_BASE_ADDRESS: begin
                        r_base <= i_cfg_data;
                    end
                    fcpa_pkg::CFG_CHUNK_BYTES: begin
                        r_chunk <= i_cfg_data[fcpa_pkg::CHUNK_W-1:0];
                    end
                    fcpa_pkg::CFG_CHUNKS_IN_USE: begin
                        r_cnt_cfg <= i_cfg_data[fcpa_pkg::COUNT_W-1:0];
                    end
                    fcpa_pkg::CFG_CHECK_OFF: begin
                        r_check_off <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cnt_write) begin
                r_count <= n_cfg_count;
                r_vld   <= '0;
            end else if (i_cmd.pop) begin
                r_count <= count_dec;
            end else if (push) begin
                r_count         <= r_count + fcpa_pkg::COUNT_W'(1);
                r_vld[push_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[push_idx] <= quo[fcpa_pkg::IDX_W-1:0];
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[pop_idx];
            r_rd_vld  <= r_vld[pop_idx];
            r_rd_idx  <= pop_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_addr   <= i_release_address;
            r_skip   <= i_skip_check;
        end
        if (i_cmd.mul) begin
            r_prod <= fcpa_pkg::PROD_W'(idx_eff) * fcpa_pkg::PROD_W'(eff_chunk);
        end
        if (i_cmd.add) begin
            r_status   <= fcpa_pkg::ST_OK;
            r_res_addr <= r_base + fcpa_pkg::ADDR_W'(r_prod);
        end else if (i_cmd.set_full) begin
            r_status   <= fcpa_pkg::ST_FULL;
            r_res_addr <= '0;
        end else if (i_cmd.check) begin
            r_res_addr <= '0;
            if (bad) begin
                r_status <= fcpa_pkg::ST_BAD_ADDR;
            end else if (all_free) begin
                r_status <= fcpa_pkg::ST_ALL_FREE;
            end else begin
                r_status <= fcpa_pkg::ST_OK;
            end
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_addr   <= r_res_addr;
            r_o_free   <= r_count;
        end
    end

    assign o_stat.is_release = (r_action == fcpa_pkg::ACT_RELEASE);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.div_busy   = div_busy;
    assign o_status          = r_o_status;
    assign o_chunk_address   = r_o_addr;
    assign o_free_chunks     = r_o_free;

endmodule

/* hw/rtl/fcpa_ctrl.sv */
module fcpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  fcpa_pkg::t_stat i_stat,
    output fcpa_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        n_state  = r_state;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_release) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_stat.empty) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_FIN;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/fixed_chunk_pool_allocator.sv */
// allocate: load, pop from the free stack, multiply, add the base, then emit the result
// allocate from an empty pool: load, then the result is set to full and emitted
// release: load, start the divider, wait while it is busy, check the address, then emit;
// the 32-step serial divider forms (address - base) / chunk size
// one item in flight; a new item is taken while the last result waits at the output
// synchronous active-low reset: registers to defaults, free stack full, no clearing pass
module fixed_chunk_pool_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fcpa_pkg::ADDR_W-1:0]    i_cfg_data,
    fcpa_in_if.sink                        i_item,
    fcpa_out_if.source                     o_result
);

    fcpa_pkg::t_cmd  cmd;
    fcpa_pkg::t_stat stat;

    fcpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fcpa_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_item.action),
        .i_release_address (i_item.release_address),
        .i_skip_check      (i_item.skip_check),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_result.status),
        .o_chunk_address   (o_result.chunk_address),
        .o_free_chunks     (o_result.free_chunks)
    );

endmodule

/* sim/tb_top.sv */
module tb_top;

    localparam int ADDR_W     = fcpa_pkg::ADDR_W;
    localparam int CHUNK_W    = fcpa_pkg::CHUNK_W;
    localparam int COUNT_W    = fcpa_pkg::COUNT_W;
    localparam int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS;
    localparam int IDX_W      = fcpa_pkg::IDX_W;
    localparam int CFG_IDX_W  = fcpa_pkg::CFG_IDX_W;
    localparam int STATUS_W   = fcpa_pkg::STATUS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = fcpa_pkg::CFG_BASE_ADDRESS;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = fcpa_pkg::CFG_CHUNK_BYTES;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE = fcpa_pkg::CFG_CHUNKS_IN_USE;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_OFF     = fcpa_pkg::CFG_CHECK_OFF;

    localparam logic [STATUS_W-1:0] ST_OK       = fcpa_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_FULL     = fcpa_pkg::ST_FULL;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = fcpa_pkg::ST_BAD_ADDR;
    localparam logic [STATUS_W-1:0] ST_ALL_FREE = fcpa_pkg::ST_ALL_FREE;

    localparam logic ACT_ALLOC   = fcpa_pkg::ACT_ALLOC;
    localparam logic ACT_RELEASE = fcpa_pkg::ACT_RELEASE;

    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 75;
    localparam int QUIET_TAIL  = 60;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   chunk_address;
        logic [COUNT_W-1:0]  free_chunks;
    } t_outcome;

    // shadow copy of the pool: registers, free stack and the outcomes still owed
    class pool_shadow;
        logic [ADDR_W-1:0]  base_address;
        logic [CHUNK_W-1:0] chunk_bytes;
        logic [COUNT_W-1:0] chunks_in_use;
        logic               check_off;
        logic [IDX_W-1:0]   free_stack [MAX_CHUNKS];
        logic [COUNT_W-1:0] free_count;
        logic [IDX_W-1:0]   taken_index;
        t_outcome           owed [$];
        int                 mismatches;

        function new();
            base_address  = '0;
            chunk_bytes   = CHUNK_W'(64);
            chunks_in_use = COUNT_W'(MAX_CHUNKS);
            check_off     = 1'b0;
            mismatches    = 0;
            refill();
        endfunction

        function logic [CHUNK_W-1:0] eff_chunk();
            return (chunk_bytes == '0) ? CHUNK_W'(1) : chunk_bytes;
        endfunction

        function logic [COUNT_W-1:0] eff_count();
            return (chunks_in_use > MAX_CHUNKS) ? COUNT_W'(MAX_CHUNKS) : chunks_in_use;
        endfunction

        function void refill();
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                free_stack[i] = IDX_W'(i);
            end
            free_count = eff_count();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
            case (idx)
                CFG_BASE_ADDRESS:  base_address = data;
                CFG_CHUNK_BYTES:   chunk_bytes = data[CHUNK_W-1:0];
                CFG_CHUNKS_IN_USE: begin
                    chunks_in_use = data[COUNT_W-1:0];
                    refill();
                end
                CFG_CHECK_OFF:     check_off = data[0];
                default: ;
            endcase
        endfunction

        // in range without wrapping, and on a chunk boundary
        function bit address_valid(logic [ADDR_W-1:0] addr);
            logic [63:0] size;
            logic [63:0] span;
            logic [63:0] offset;
            size = 64'(eff_chunk());
            span = 64'(eff_count()) * size;
            if (addr < base_address) return 1'b0;
            offset = 64'(addr) - 64'(base_address);
            if (offset >= span) return 1'b0;
            return (offset % size) == 64'd0;
        endfunction

        function t_outcome take_request(logic act, logic [ADDR_W-1:0] addr, logic skip);
            t_outcome          res;
            logic [ADDR_W-1:0] quotient;
            res = '0;
            res.status = ST_OK;
            if (act == ACT_ALLOC) begin
                if (free_count == '0) begin
                    res.status = ST_FULL;
                end else begin
                    free_count = free_count - 1'b1;
                    taken_index = free_stack[free_count[IDX_W-1:0]];
                    res.chunk_address = base_address
                                        + ADDR_W'(taken_index) * ADDR_W'(eff_chunk());
                end
            end else if (!skip && !check_off && !address_valid(addr)) begin
                res.status = ST_BAD_ADDR;
            end else if (free_count >= eff_count()) begin
                res.status = ST_ALL_FREE;
            end else begin
                // offset wraps modulo 2^32, the index keeps only its low bits
                quotient = (addr - base_address) / ADDR_W'(eff_chunk());
                free_stack[free_count[IDX_W-1:0]] = quotient[IDX_W-1:0];
                free_count = free_count + 1'b1;
            end
            res.free_chunks = free_count;
            owed = {owed, res};
            return res;
        endfunction

        function void match_outcome(t_outcome got);
            t_outcome want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d address %h free %0d",
                             got.status, got.chunk_address, got.free_chunks);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.chunk_address !== want.chunk_address
                    || got.free_chunks !== want.free_chunks) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d address %h free %0d, got %0d %h %0d",
                             want.status, want.chunk_address, want.free_chunks,
                             got.status, got.chunk_address, got.free_chunks);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0]    i_cfg_data;

    fcpa_in_if  item_if ();
    fcpa_out_if result_if ();

    fixed_chunk_pool_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    pool_shadow shadow = new();
    int         live_idx [$];
    int         src_idle_pct;
    int         snk_idle_pct;
    bit         quiet;
    bit         hold_now;
    int         cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            shadow.match_outcome({result_if.status, result_if.chunk_address,
                                  result_if.free_chunks});
    end

    // result side: random stalls, plus one long hold-off to fill the block
    initial begin
        result_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_now) begin
                result_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_now = 1'b0;
                result_if.ready = 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
                result_if.ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                result_if.ready = 1'b1;
            end
        end
    end

    task automatic offer(input logic act, input logic [ADDR_W-1:0] addr, input logic skip);
        t_outcome res;
        @(negedge i_clk);
        item_if.valid           = 1'b1;
        item_if.action          = act;
        item_if.release_address = addr;
        item_if.skip_check      = skip;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        res = shadow.take_request(act, addr, skip);
        if (act == ACT_ALLOC && res.status == ST_OK)
            live_idx = {live_idx, int'(shadow.taken_index)};
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            item_if.valid = 1'b0;
        end
    endtask

    task automatic settle();
        idle_sender(1);
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow.write_reg(idx, data);
        if (idx == CFG_CHUNKS_IN_USE) live_idx.delete();
    endtask

    task automatic new_setting(input int phase);
        logic [ADDR_W-1:0]  base;
        logic [CHUNK_W-1:0] size;
        logic [COUNT_W-1:0] count;
        logic [31:0]        junk;
        case ($urandom_range(0, 4))
            0:       base = '0;
            1:       base = '1;
            2:       base = $urandom();
            3:       base = $urandom() & 32'hFFFF_0000;
            default: base = 32'h8000_0000;
        endcase
        case ($urandom_range(0, 5))
            0:       size = '0;
            1:       size = CHUNK_W'(1);
            2:       size = CHUNK_W'(65536);
            3:       size = '1;
            4:       size = CHUNK_W'($urandom_range(1, 512));
            default: size = CHUNK_W'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0:       count = '0;
            1:       count = COUNT_W'(1);
            2:       count = COUNT_W'($urandom_range(2, 8));
            3:       count = COUNT_W'(MAX_CHUNKS);
            4:       count = COUNT_W'($urandom_range(257, 511));
            default: count = COUNT_W'($urandom_range(1, MAX_CHUNKS));
        endcase
        // a tiny pool first so full and all-free come often, then a plain wide one
        if (phase == 0) count = COUNT_W'(4);
        if (phase == 1) begin
            base  = '0;
            size  = CHUNK_W'(64);
            count = COUNT_W'(MAX_CHUNKS);
        end
        junk = $urandom();
        settle();
        set_reg(CFG_BASE_ADDRESS, base);
        set_reg(CFG_CHUNK_BYTES, {junk[31:CHUNK_W], size});
        if (phase < 2 || $urandom_range(0, 3) != 0)
            set_reg(CFG_CHUNKS_IN_USE, {junk[31:COUNT_W], count});
        set_reg(CFG_CHECK_OFF, {junk[31:1], 1'($urandom_range(0, 3) == 0)});
    endtask

    task automatic random_item(input int alloc_pct);
        int                 pick;
        int                 k;
        logic [ADDR_W-1:0]  addr;
        logic [CHUNK_W-1:0] size;
        logic               skip;
        size = shadow.eff_chunk();
        skip = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 99) < alloc_pct) begin
            offer(ACT_ALLOC, $urandom(), 1'($urandom_range(0, 1)));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65 && live_idx.size() > 0) begin
            k = $urandom_range(0, live_idx.size() - 1);
            addr = shadow.base_address + ADDR_W'(live_idx[k]) * ADDR_W'(size);
            live_idx.delete(k);
        end else if (pick < 78) begin
            // off the chunk grid, near the pool
            addr = shadow.base_address
                   + ADDR_W'($urandom_range(0, shadow.eff_count())) * ADDR_W'(size)
                   + ((size > 1) ? ADDR_W'($urandom_range(1, size - 1)) : ADDR_W'(0));
        end else if (pick < 90) begin
            addr = $urandom();
            skip = 1'($urandom_range(0, 1));
        end else begin
            // on the grid: double release or just past the end
            addr = shadow.base_address
                   + ADDR_W'($urandom_range(0, shadow.eff_count())) * ADDR_W'(size);
        end
        offer(ACT_RELEASE, addr, skip);
    endtask

    initial begin
        int phase;
        int n;
        int alloc_pct;
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = CFG_BASE_ADDRESS;
        i_cfg_data              = '0;
        item_if.valid           = 1'b0;
        item_if.action          = ACT_ALLOC;
        item_if.release_address = '0;
        item_if.skip_check      = 1'b0;
        quiet                   = 1'b0;
        hold_now                = 1'b0;
        src_idle_pct            = 0;
        snk_idle_pct            = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: release into a full free stack, checks, skipped check
        offer(ACT_RELEASE, 32'h0000_0000, 1'b0);
        offer(ACT_RELEASE, 32'h0000_0001, 1'b0);
        offer(ACT_RELEASE, 32'hFFFF_FFFF, 1'b1);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_RELEASE, 32'd254 * 32'd64, 1'b0);
        offer(ACT_RELEASE, 32'd256 * 32'd64, 1'b0);
        offer(ACT_RELEASE, 32'hFFFF_FFC0, 1'b1);

        // empty pool
        settle();
        set_reg(CFG_CHUNKS_IN_USE, 32'h0);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_RELEASE, 32'h0, 1'b0);
        offer(ACT_RELEASE, 32'h0, 1'b1);

        // one chunk at the top of the address space, zero chunk size
        settle();
        set_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        set_reg(CFG_CHUNK_BYTES, 32'h0);
        set_reg(CFG_CHUNKS_IN_USE, 32'h1);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_RELEASE, 32'h0, 1'b0);
        offer(ACT_RELEASE, 32'hFFFF_FFFF, 1'b0);

        // chunk count clipped, allocations that wrap past 2^32
        settle();
        set_reg(CFG_BASE_ADDRESS, 32'hFFFF_0000);
        set_reg(CFG_CHUNK_BYTES, 32'h0001_0000);
        set_reg(CFG_CHUNKS_IN_USE, 32'h0000_01FF);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_ALLOC, 32'h0, 1'b0);
        offer(ACT_RELEASE, 32'h00FE_0000, 1'b0);
        settle();
        set_reg(CFG_CHECK_OFF, 32'h1);
        offer(ACT_RELEASE, 32'h00FE_0000, 1'b0);
        offer(ACT_RELEASE, 32'h1234_5677, 1'b0);
        offer(ACT_RELEASE, 32'h0, 1'b0);
        // widest chunk size, stack kept as it was
        settle();
        set_reg(CFG_CHUNK_BYTES, 32'hFFFF_FFFF);
        offer(ACT_ALLOC, 32'h0, 1'b0);

        for (phase = 0; phase < PHASES; phase++) begin
            new_setting(phase);
            case ($urandom_range(0, 2))
                0:       alloc_pct = 35;
                1:       alloc_pct = 50;
                default: alloc_pct = 70;
            endcase
            case ($urandom_range(0, 2))
                0:       src_idle_pct = 0;
                1:       src_idle_pct = 25;
                default: src_idle_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0:       snk_idle_pct = 0;
                1:       snk_idle_pct = 25;
                default: snk_idle_pct = 60;
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (phase * PHASE_ITEMS + n) >= (PHASES * PHASE_ITEMS - QUIET_TAIL);
                if (phase == 1 && n == 20) hold_now = 1'b1;
                if (!quiet && !hold_now && $urandom_range(0, 99) < src_idle_pct)
                    idle_sender($urandom_range(1, 7));
                random_item(alloc_pct);
            end
        end

        idle_sender(1);
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
